FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPL(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

FILE: rtl/rob_pkg.sv
package rob_pkg;

  localparam int unsigned TAG_W       = 6;
  localparam int unsigned REG_W       = 6;
  localparam int unsigned SEQ_W       = 32;
  localparam int unsigned ENTRY_IDX_W = 5;
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned CFG_AE_W    = 6;

  localparam logic REG_IDX_ACTIVE_ENTRIES = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT     = 3'd0,
    CMD_MARK_EXEC  = 3'd1,
    CMD_MARK_READY = 3'd2,
    CMD_WAKEUP     = 3'd3,
    CMD_CHECK      = 3'd4,
    CMD_REMOVE     = 3'd5
  } cmd_t;

  typedef struct packed {
    logic             rdy;
    logic [TAG_W-1:0] tag;
  } src_t;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [REG_W-1:0] rs1;
    logic [REG_W-1:0] rs2;
    logic [REG_W-1:0] rd;
    logic [TAG_W-1:0] dest_tag;
  } rec_t;

  typedef struct packed {
    logic                   accepted;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic                   tag_ready;
    logic                   has_space;
    logic                   head_ready;
    logic                   committed;
    rec_t                   rec;
  } res_t;

endpackage

FILE: rtl/rob_rec_mem.sv
module rob_rec_mem
  import rob_pkg::*;
#(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  rec_t          wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output rec_t          rd_data
);

  rec_t mem [DEPTH];
  rec_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/rob_wake.sv
module rob_wake
  import rob_pkg::*;
#(
  parameter int unsigned N  = 32,
  parameter int unsigned AW = 5
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_idx,
  input  src_t             wr_src1,
  input  src_t             wr_src2,
  input  logic             wake_en,
  input  logic [TAG_W-1:0] wake_tag,
  input  logic [N-1:0]     elig,
  output logic [N-1:0]     src1_rdy,
  output logic [N-1:0]     src2_rdy
);

  src_t src1_r [N];
  src_t src2_r [N];

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (wr_en && (wr_idx == AW'(i))) begin
        src1_r[i] <= wr_src1;
        src2_r[i] <= wr_src2;
      end else if (wake_en && elig[i]) begin
        if (src1_r[i].tag == wake_tag) begin
          src1_r[i].rdy <= 1'b1;
        end
        if (src2_r[i].tag == wake_tag) begin
          src2_r[i].rdy <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      src1_rdy[i] = src1_r[i].rdy;
      src2_rdy[i] = src2_r[i].rdy;
    end
  end

endmodule

FILE: rtl/rob_outq.sv
module rob_outq
  import rob_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  input  logic pop_ready,
  output logic out_valid,
  output res_t out_data,
  output logic full
);

  res_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign out_data  = slot_r[rd_ptr_r];
  assign pop       = out_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/reorder_buffer_with_wakeup.sv
// Reorder buffer of up to ROB_ENTRIES slots with operand wakeup. The slot count in use is set
// by the active_entries register (held to 2..ROB_ENTRIES) and one slot always stays empty.
// Every command except remove pushes its result into the output queue when it is taken; remove
// first waits in S_READ, taking no new command, as the head record comes from the synchronous
// record memory, whose read data is registered. Results pass through a two-entry output queue,
// so a new command is taken while up to one result still waits on the output side.
`include "assert_macros.svh"

module reorder_buffer_with_wakeup
  import rob_pkg::*;
#(
  parameter int unsigned ROB_ENTRIES = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [CMD_W-1:0]       in_cmd,
  input  logic signed [TAG_W-1:0] in_tag,
  input  logic [SEQ_W-1:0]       in_inst_num,
  input  logic signed [REG_W-1:0] in_src1_reg,
  input  logic                   in_src1_ready,
  input  logic signed [TAG_W-1:0] in_src1_tag,
  input  logic signed [REG_W-1:0] in_src2_reg,
  input  logic                   in_src2_ready,
  input  logic signed [TAG_W-1:0] in_src2_tag,
  input  logic signed [REG_W-1:0] in_dest_reg,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_accepted,
  output logic [ENTRY_IDX_W-1:0] out_entry_index,
  output logic                   out_tag_ready,
  output logic                   out_has_space,
  output logic                   out_head_ready,
  output logic                   out_committed,
  output logic [SEQ_W-1:0]       out_head_inst_num,
  output logic signed [REG_W-1:0] out_head_src1_reg,
  output logic signed [REG_W-1:0] out_head_src2_reg,
  output logic signed [REG_W-1:0] out_head_dest_reg,
  output logic signed [TAG_W-1:0] out_head_dest_tag
);

  localparam int unsigned IDX_W = (ROB_ENTRIES > 1) ? $clog2(ROB_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ROB_ENTRIES + 1);
  localparam int unsigned SZ_W  = (CNT_W > CFG_AE_W) ? CNT_W : CFG_AE_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t               state_r, state_nxt;
  logic [CFG_AE_W-1:0]  active_entries_r;
  logic [IDX_W-1:0]     head_r, head_nxt;
  logic [IDX_W-1:0]     tail_r, tail_nxt;
  logic [ROB_ENTRIES-1:0] valid_r, valid_nxt;
  logic [ROB_ENTRIES-1:0] exec_r, exec_nxt;
  logic [ROB_ENTRIES-1:0] ready_r, ready_nxt;
  logic [ROB_ENTRIES-1:0] elig;
  logic [ROB_ENTRIES-1:0] src1_rdy;
  logic [ROB_ENTRIES-1:0] src2_rdy;
  res_t                 pend_r;
  res_t                 res_now;
  res_t                 q_data;
  res_t                 q_out;
  logic                 q_push;
  logic                 q_full;
  logic [SZ_W-1:0]      n_slots;
  logic [SZ_W-1:0]      ae_ext;
  logic                 in_fire;
  logic                 space_now;
  logic                 tslot_ok;
  logic [IDX_W-1:0]     tslot;
  logic                 head_ok;
  logic                 ins_wr;
  logic                 rd_en;
  logic                 wake_en;
  logic                 cfg_wr;
  rec_t                 ins_rec;
  rec_t                 rd_rec;
  src_t                 ins_src1;
  src_t                 ins_src2;

  function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] p,
                                          input logic [SZ_W-1:0] sz);
    logic [SZ_W-1:0] q;
    q = SZ_W'(p) + SZ_W'(1);
    return (q >= sz) ? '0 : q[IDX_W-1:0];
  endfunction

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_IDX_ACTIVE_ENTRIES) begin
      prdata = 32'(active_entries_r);
    end
  end

  always_comb begin
    ae_ext = SZ_W'(active_entries_r);
    if (ae_ext < SZ_W'(2)) begin
      n_slots = SZ_W'(2);
    end else if (ae_ext > SZ_W'(ROB_ENTRIES)) begin
      n_slots = SZ_W'(ROB_ENTRIES);
    end else begin
      n_slots = ae_ext;
    end
  end

  assign in_ready = (state_r == S_IDLE) && !q_full;
  assign in_fire  = in_valid && in_ready;

  assign space_now = (adv(tail_r, n_slots) != head_r);
  assign tslot_ok  = !in_tag[5] && (SZ_W'(in_tag[4:0]) < n_slots);
  assign tslot     = IDX_W'(in_tag[4:0]);
  assign head_ok   = valid_r[head_r] && ready_r[head_r];

  assign ins_rec.seq      = in_inst_num;
  assign ins_rec.rs1      = in_src1_reg;
  assign ins_rec.rs2      = in_src2_reg;
  assign ins_rec.rd       = in_dest_reg;
  assign ins_rec.dest_tag = in_tag;
  assign ins_src1.rdy     = in_src1_ready;
  assign ins_src1.tag     = in_src1_tag;
  assign ins_src2.rdy     = in_src2_ready;
  assign ins_src2.tag     = in_src2_tag;

  always_comb begin
    for (int i = 0; i < ROB_ENTRIES; i++) begin
      elig[i] = valid_r[i] && (SZ_W'(i) < n_slots);
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    exec_nxt  = exec_r;
    ready_nxt = ready_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    ins_wr    = 1'b0;
    rd_en     = 1'b0;
    wake_en   = 1'b0;
    res_now   = '0;
    case (cmd_t'(in_cmd))
      CMD_INSERT: begin
        if (space_now) begin
          ins_wr               = in_fire;
          valid_nxt[tail_r]    = 1'b1;
          exec_nxt[tail_r]     = 1'b0;
          ready_nxt[tail_r]    = 1'b0;
          tail_nxt             = adv(tail_r, n_slots);
          res_now.accepted     = 1'b1;
          res_now.entry_index  = ENTRY_IDX_W'(tail_r);
        end
      end
      CMD_MARK_EXEC: begin
        if (tslot_ok) begin
          exec_nxt[tslot] = 1'b1;
        end
      end
      CMD_MARK_READY: begin
        if (tslot_ok) begin
          ready_nxt[tslot] = 1'b1;
        end
      end
      CMD_WAKEUP: begin
        wake_en = in_fire;
      end
      CMD_CHECK: begin
        res_now.tag_ready = tslot_ok && valid_r[tslot] && ready_r[tslot];
      end
      CMD_REMOVE: begin
        rd_en = in_fire;
        if (head_ok) begin
          valid_nxt[head_r] = 1'b0;
          exec_nxt[head_r]  = 1'b0;
          ready_nxt[head_r] = 1'b0;
          head_nxt          = adv(head_r, n_slots);
          res_now.committed = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res_now.has_space  = (adv(tail_nxt, n_slots) != head_nxt);
    res_now.head_ready = valid_nxt[head_nxt] && ready_nxt[head_nxt];
  end

  always_comb begin
    state_nxt = state_r;
    q_push    = 1'b0;
    q_data    = res_now;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (cmd_t'(in_cmd) == CMD_REMOVE) begin
            state_nxt = S_READ;
          end else begin
            q_push = 1'b1;
          end
        end
      end
      S_READ: begin
        q_push    = 1'b1;
        q_data    = pend_r;
        q_data.rec = pend_r.committed ? rd_rec : '0;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_r <= res_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      active_entries_r <= CFG_AE_W'(32);
      head_r           <= '0;
      tail_r           <= '0;
      valid_r          <= '0;
      exec_r           <= '0;
      ready_r          <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && (paddr[2] == REG_IDX_ACTIVE_ENTRIES)) begin
        active_entries_r <= pwdata[CFG_AE_W-1:0];
      end
      if (in_fire) begin
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        valid_r <= valid_nxt;
        exec_r  <= exec_nxt;
        ready_r <= ready_nxt;
      end
    end
  end

  rob_rec_mem #(
    .DEPTH (ROB_ENTRIES),
    .AW    (IDX_W)
  ) u_rec_mem (
    .clk     (clk),
    .wr_en   (ins_wr),
    .wr_addr (tail_r),
    .wr_data (ins_rec),
    .rd_en   (rd_en),
    .rd_addr (head_r),
    .rd_data (rd_rec)
  );

  rob_wake #(
    .N  (ROB_ENTRIES),
    .AW (IDX_W)
  ) u_wake (
    .clk      (clk),
    .wr_en    (ins_wr),
    .wr_idx   (tail_r),
    .wr_src1  (ins_src1),
    .wr_src2  (ins_src2),
    .wake_en  (wake_en),
    .wake_tag (in_tag),
    .elig     (elig),
    .src1_rdy (src1_rdy),
    .src2_rdy (src2_rdy)
  );

  rob_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (q_out),
    .full      (q_full)
  );

  assign out_accepted      = q_out.accepted;
  assign out_entry_index   = q_out.entry_index;
  assign out_tag_ready     = q_out.tag_ready;
  assign out_has_space     = q_out.has_space;
  assign out_head_ready    = q_out.head_ready;
  assign out_committed     = q_out.committed;
  assign out_head_inst_num = q_out.rec.seq;
  assign out_head_src1_reg = q_out.rec.rs1;
  assign out_head_src2_reg = q_out.rec.rs2;
  assign out_head_dest_reg = q_out.rec.rd;
  assign out_head_dest_tag = q_out.rec.dest_tag;

  `CHK_NEXT(a_commit_moves_head, clk, rst_n,
            in_fire && (cmd_t'(in_cmd) == CMD_REMOVE) && head_ok,
            (head_r != $past(head_r)) && !valid_r[$past(head_r)])
  `CHK_NEXT(a_insert_sets_valid, clk, rst_n,
            ins_wr, valid_r[$past(tail_r)] && !ready_r[$past(tail_r)])
  `CHK_NEXT(a_remove_result_follows, clk, rst_n,
            in_fire && (cmd_t'(in_cmd) == CMD_REMOVE), q_push && !in_ready)
  `CHK_NEXT(a_insert_src_ready, clk, rst_n,
            ins_wr && in_src1_ready && in_src2_ready,
            src1_rdy[$past(tail_r)] && src2_rdy[$past(tail_r)])

endmodule
